// ===== src/vpa_pkg.sv =====
// Shared constants and types of the variable partition allocator.
package vpa_pkg;
	localparam int MAX_BLOCKS = 32;
	localparam int ADDR_BITS = 16;
	localparam int OWNER_BITS = 8;
	localparam int IDX_BITS = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
	localparam int LEN_BITS = ADDR_BITS + 1;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_NO_HOLE = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_BAD = 3'd3;
	localparam logic [2:0] ST_NO_OWNER = 3'd4;

	localparam logic CFG_FIT = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	// Fit policies; the fourth code behaves as first fit.
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_ALT = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	typedef struct packed {
		logic [ADDR_BITS-1:0] seg_start;
		logic [ADDR_BITS-1:0] seg_end;
		logic [OWNER_BITS-1:0] owner;
		logic used;
	} seg_t;

	// Command to all cells for one cycle.
	typedef enum logic [2:0] {
		OP_HOLD, OP_INIT, OP_SPLIT, OP_MARK, OP_RELEASE, OP_MERGE
	} op_t;

	typedef struct packed {
		op_t op;
		logic [IDX_BITS-1:0] idx;
		logic [ADDR_BITS-1:0] split_end;
		logic [OWNER_BITS-1:0] owner;
		logic [ADDR_BITS-1:0] init_end;
	} cmd_t;
endpackage

// ===== src/variable_partition_allocator_core.sv =====
// Top level of the variable partition allocator: control sequencer and cell row.
// Allocate: accept, parallel compare, a scan slot by slot up to the pick (all slots
// for best and worst fit), update and result. Free: accept, release, a merge scan
// over the slots and result; a bad request goes straight to the result. The result
// then waits in an output register. Reset (arst_n low) gives one free block of 65536
// units and first fit.
module variable_partition_allocator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic kind,
	input  logic [16:0] request_size,
	input  logic [7:0] owner_id,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic [15:0] block_start,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [16:0] cfg_data
);
	localparam int AB = vpa_pkg::ADDR_BITS;
	localparam int IB = vpa_pkg::IDX_BITS;
	localparam int LB = vpa_pkg::LEN_BITS;

	typedef enum logic [2:0] {S_IDLE, S_FIT, S_SCAN, S_UPD, S_MERGE, S_OUT} state_t;

	state_t state_q;
	logic [1:0] fit_q;
	logic kind_q;
	logic [LB-1:0] req_q;
	logic [vpa_pkg::OWNER_BITS-1:0] own_q;
	logic [IB-1:0] scan_q;
	logic [IB:0] pick_q;  // msb set means no pick
	logic [LB-1:0] plen_q;
	logic [vpa_pkg::CNT_BITS-1:0] cnt_q;
	logic [vpa_pkg::MAX_BLOCKS-1:0] fits_q;
	logic [2:0] st_q;
	logic [AB-1:0] bs_q;
	logic found_q;
	logic out_vld_q;
	logic [2:0] out_st_q;
	logic [AB-1:0] out_bs_q;
	vpa_pkg::cmd_t cmd;
	vpa_pkg::seg_t segs [vpa_pkg::MAX_BLOCKS];

	vpa_chain u_chain (.clk(clk), .arst_n(arst_n), .cmd(cmd), .segs(segs));

	// Clamp memory size to 1..2^ADDR_BITS, then the end address is size minus one.
	logic [AB-1:0] init_end;
	always_comb begin
		logic [16:0] v;
		v = cfg_data;
		if (v == '0) v = 17'd1;
		if (v > 17'(1 << AB)) v = 17'(1 << AB);
		init_end = AB'(v - 17'd1);
	end

	logic [vpa_pkg::OWNER_BITS-1:0] in_own;
	assign in_own = vpa_pkg::OWNER_BITS'(owner_id);
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	// The output register lets the sequencer go idle while a result is stalled.
	assign out_valid = out_vld_q;
	assign status = out_st_q;
	assign block_start = out_bs_q;

	logic in_xfer, cfg_xfer, out_load;
	assign in_xfer = in_valid && !in_stall;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign out_load = (state_q == S_OUT) && (!out_vld_q || !out_stall);

	// Every cell is compared in parallel: free holes large enough for the request
	// and slots held by the owner being released.
	logic [vpa_pkg::MAX_BLOCKS-1:0] fits_d;
	logic [vpa_pkg::MAX_BLOCKS-1:0] own_hit;
	always_comb begin
		for (int k = 0; k < vpa_pkg::MAX_BLOCKS; k++) begin
			fits_d[k] = segs[k].used && segs[k].owner == '0 &&
				(LB'(segs[k].seg_end) - LB'(segs[k].seg_start) + 1'b1) >= req_q;
			own_hit[k] = segs[k].used && segs[k].owner == own_q;
		end
	end

	// Scanned slot and its length.
	vpa_pkg::seg_t sc;
	logic [LB-1:0] sc_len;
	assign sc = segs[scan_q];
	assign sc_len = LB'(sc.seg_end) - LB'(sc.seg_start) + 1'b1;
	vpa_pkg::seg_t pk;
	assign pk = segs[pick_q[IB-1:0]];
	vpa_pkg::seg_t nx;
	logic last_slot;
	assign last_slot = (scan_q == IB'(vpa_pkg::MAX_BLOCKS - 1));
	assign nx = last_slot ? '0 : segs[scan_q + 1'b1];

	always_comb begin
		cmd = '0;
		cmd.op = vpa_pkg::OP_HOLD;
		cmd.owner = own_q;
		cmd.idx = pick_q[IB-1:0];
		cmd.init_end = init_end;
		cmd.split_end = AB'(LB'(pk.seg_start) + req_q - 1'b1);
		if (cfg_xfer && cfg_index == vpa_pkg::CFG_SIZE) cmd.op = vpa_pkg::OP_INIT;
		else if (state_q == S_UPD) begin
			if (!pick_q[IB] && plen_q == req_q) cmd.op = vpa_pkg::OP_MARK;
			else if (!pick_q[IB] && cnt_q < vpa_pkg::CNT_BITS'(vpa_pkg::MAX_BLOCKS))
				cmd.op = vpa_pkg::OP_SPLIT;
		end else if (state_q == S_FIT && kind_q == vpa_pkg::KIND_FREE)
			cmd.op = vpa_pkg::OP_RELEASE;
		else if (state_q == S_MERGE && !last_slot && sc.used && nx.used &&
				sc.owner == '0 && nx.owner == '0) begin
			cmd.op = vpa_pkg::OP_MERGE;
			cmd.idx = scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fit_q <= vpa_pkg::FIT_FIRST;
			cnt_q <= vpa_pkg::CNT_BITS'(1);
			kind_q <= vpa_pkg::KIND_ALLOC;
			req_q <= '0;
			own_q <= '0;
			scan_q <= '0;
			pick_q <= {1'b1, IB'(0)};
			plen_q <= '0;
			fits_q <= '0;
			st_q <= vpa_pkg::ST_DONE;
			bs_q <= '0;
			found_q <= 1'b0;
			out_vld_q <= 1'b0;
			out_st_q <= vpa_pkg::ST_DONE;
			out_bs_q <= '0;
		end else begin
			if (cfg_xfer) begin
				if (cfg_index == vpa_pkg::CFG_FIT) fit_q <= cfg_data[1:0];
				else begin
					cnt_q <= vpa_pkg::CNT_BITS'(1);
				end
			end
			// A finished result moves into the output register once it is free.
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_st_q <= st_q;
				out_bs_q <= bs_q;
			end else if (!out_stall) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_xfer) begin
					kind_q <= kind;
					req_q <= request_size;
					own_q <= in_own;
					bs_q <= '0;
					scan_q <= '0;
					pick_q <= {1'b1, IB'(0)};
					found_q <= 1'b0;
					if (in_own == '0) begin
						st_q <= vpa_pkg::ST_BAD;
						state_q <= S_OUT;
					end else if (kind == vpa_pkg::KIND_ALLOC && request_size == '0) begin
						st_q <= vpa_pkg::ST_BAD;
						state_q <= S_OUT;
					end else state_q <= S_FIT;
				end
				S_FIT: begin
					// The parallel compare flags are registered here.
					fits_q <= fits_d;
					found_q <= |own_hit;
					state_q <= (kind_q == vpa_pkg::KIND_FREE) ? S_MERGE : S_SCAN;
				end
				S_SCAN: begin
					if (fits_q[scan_q]) begin
						if (pick_q[IB] || (fit_q == vpa_pkg::FIT_BEST && sc_len < plen_q) ||
								(fit_q == vpa_pkg::FIT_WORST && sc_len > plen_q)) begin
							pick_q <= {1'b0, scan_q};
							plen_q <= sc_len;
						end
					end
					scan_q <= scan_q + 1'b1;
					if (last_slot || (fits_q[scan_q] &&
							(fit_q inside {vpa_pkg::FIT_FIRST, vpa_pkg::FIT_ALT})))
						state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_OUT;
					if (pick_q[IB]) st_q <= vpa_pkg::ST_NO_HOLE;
					else if (plen_q == req_q) begin
						st_q <= vpa_pkg::ST_DONE;
						bs_q <= pk.seg_start;
					end else if (cnt_q >= vpa_pkg::CNT_BITS'(vpa_pkg::MAX_BLOCKS))
						st_q <= vpa_pkg::ST_FULL;
					else begin
						st_q <= vpa_pkg::ST_DONE;
						bs_q <= pk.seg_start;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MERGE: begin
					if (!found_q) begin
						st_q <= vpa_pkg::ST_NO_OWNER;
						state_q <= S_OUT;
					end else if (cmd.op == vpa_pkg::OP_MERGE) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (last_slot || !nx.used) begin
						st_q <= vpa_pkg::ST_DONE;
						state_q <= S_OUT;
					end else scan_q <= scan_q + 1'b1;
				end
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/vpa_cell.sv =====
// One table slot; shifts to the right on split and to the left on merge.
module vpa_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [vpa_pkg::IDX_BITS-1:0] my_idx,
	input  vpa_pkg::cmd_t cmd,
	input  vpa_pkg::seg_t left_seg,
	input  vpa_pkg::seg_t right_seg,
	output vpa_pkg::seg_t seg
);
	vpa_pkg::seg_t seg_q;
	vpa_pkg::seg_t seg_d;
	vpa_pkg::seg_t boot_seg;
	assign seg = seg_q;

	// Slot zero comes out of reset as one free block over the full range.
	always_comb begin
		boot_seg = '0;
		if (my_idx == '0) begin
			boot_seg.seg_end = '1;
			boot_seg.used = 1'b1;
		end
	end

	always_comb begin
		seg_d = seg_q;
		case (cmd.op)
			vpa_pkg::OP_INIT: begin
				seg_d = '0;
				if (my_idx == '0) begin
					seg_d.seg_end = cmd.init_end;
					seg_d.used = 1'b1;
				end
			end
			vpa_pkg::OP_SPLIT: begin
				if (my_idx == cmd.idx) begin
					seg_d.seg_end = cmd.split_end;
					seg_d.owner = cmd.owner;
				end else if (my_idx == cmd.idx + 1'b1) begin
					seg_d.seg_start = cmd.split_end + 1'b1;
					seg_d.seg_end = left_seg.seg_end;
					seg_d.owner = '0;
					seg_d.used = 1'b1;
				end else if (my_idx > cmd.idx) begin
					seg_d = left_seg;
				end
			end
			vpa_pkg::OP_MARK: begin
				if (my_idx == cmd.idx) seg_d.owner = cmd.owner;
			end
			vpa_pkg::OP_RELEASE: begin
				if (seg_q.owner == cmd.owner) seg_d.owner = '0;
			end
			vpa_pkg::OP_MERGE: begin
				if (my_idx == cmd.idx) begin
					seg_d.seg_end = right_seg.seg_end;
				end else if (my_idx > cmd.idx) begin
					seg_d = right_seg;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= boot_seg;
		end else begin
			seg_q <= seg_d;
		end
	end
endmodule

// ===== src/vpa_chain.sv =====
// Row of table cells with neighbor links.
module vpa_chain (
	input  logic clk,
	input  logic arst_n,
	input  vpa_pkg::cmd_t cmd,
	output vpa_pkg::seg_t segs [vpa_pkg::MAX_BLOCKS]
);
	for (genvar g = 0; g < vpa_pkg::MAX_BLOCKS; g++) begin : g_cell
		vpa_pkg::seg_t lft, rgt;
		if (g == 0) begin : g_l
			assign lft = '0;
		end else begin : g_l
			assign lft = segs[g-1];
		end
		if (g == vpa_pkg::MAX_BLOCKS - 1) begin : g_r
			assign rgt = '0;
		end else begin : g_r
			assign rgt = segs[g+1];
		end
		vpa_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.my_idx(vpa_pkg::IDX_BITS'(g)),
			.cmd(cmd), .left_seg(lft), .right_seg(rgt), .seg(segs[g])
		);
	end
endmodule
